// ===== hdl/lin_frame_receiver_defines.svh =====
// assertion macros shared by the receiver
`ifndef LIN_FRAME_RECEIVER_DEFINES_SVH
`define LIN_FRAME_RECEIVER_DEFINES_SVH

// check on every clock edge, suspended while reset is asserted
`define LFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check on every clock edge, reset included
`define LFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/lfr_pkg.sv =====
package lfr_pkg;

  // largest number of data bytes a frame can carry
  localparam int unsigned LFR_DATA_SLOTS = 8;
  localparam int unsigned LFR_MAX_DATA   = 8;

  // register reset values
  localparam logic [15:0] LFR_GAP_RESET  = 16'd50;
  localparam logic [7:0]  LFR_SYNC_RESET = 8'h55;
  localparam logic [63:0] LFR_MASK_RESET = 64'd0;

  // register indexes on the configuration port
  localparam logic [1:0] CFG_GAP_TICKS = 2'd0;
  localparam logic [1:0] CFG_SYNC      = 2'd1;
  localparam logic [1:0] CFG_ID_MASK   = 2'd2;

  // input item kinds
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_SYNC     = 3'd1,
    ST_PARITY      = 3'd2,
    ST_NO_BYTES    = 3'd3,
    ST_CHECKSUM    = 3'd4,
    ST_NOT_ENABLED = 3'd5
  } lfr_status_e;

  // closed frame handed from the front to the back
  typedef struct packed {
    logic                           has_id;
    logic [7:0]                     pid;
    logic [3:0]                     cnt;
    logic [7:0]                     last_byte;
    logic [LFR_DATA_SLOTS-1:0][7:0] data;
  } lfr_frame_t;

  // one result beat
  typedef struct packed {
    lfr_status_e status;
    logic [7:0]  pid;
    logic [3:0]  data_count;
    logic [2:0]  byte_index;
    logic [7:0]  data_byte;
    logic        matched_enhanced;
    logic        last;
  } lfr_result_t;

  // protected id built from a six-bit frame id
  function automatic logic [7:0] lfr_parity(input logic [5:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

  // one step of the carry-wrapped byte sum
  function automatic logic [7:0] lfr_wrap_add(input logic [7:0] s, input logic [7:0] b);
    logic [8:0] t;
    t = {1'b0, s} + {1'b0, b};
    return t[8] ? (t[7:0] + 8'd1) : t[7:0];
  endfunction

endpackage

// ===== hdl/lfr_front.sv =====
module lfr_front import lfr_pkg::*; #(
  parameter int unsigned MAX_DATA = LFR_MAX_DATA
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic        action_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [15:0] gap_ticks_i,
  input  logic [7:0]  sync_value_i,
  output logic        push_o,
  output lfr_frame_t  frame_o
);

  typedef enum logic [1:0] {
    PH_EMPTY = 2'd0,
    PH_HUNT  = 2'd1,
    PH_SYNC  = 2'd2,
    PH_ID    = 2'd3
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] idle_q, idle_d;
  logic [7:0]  pid_q, pid_d;
  logic [7:0]  last_q, last_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        store_we;
  logic [MAX_DATA-1:0][7:0] store_q;

  // frame assembly on each accepted beat
  always_comb begin
    phase_d  = phase_q;
    idle_d   = idle_q;
    pid_d    = pid_q;
    last_d   = last_q;
    cnt_d    = cnt_q;
    push_o   = 1'b0;
    store_we = 1'b0;
    if (accept_i) begin
      if (action_i == ACT_TICK) begin
        if (phase_q != PH_EMPTY) begin
          if (idle_q >= gap_ticks_i) begin
            push_o  = 1'b1;
            phase_d = PH_EMPTY;
            idle_d  = '0;
            pid_d   = '0;
            last_d  = '0;
            cnt_d   = '0;
          end else begin
            idle_d = idle_q + 16'd1;
          end
        end
      end else begin
        idle_d = '0;
        unique case (phase_q)
          PH_EMPTY, PH_HUNT: begin
            phase_d = (rx_byte_i == sync_value_i) ? PH_SYNC : PH_HUNT;
          end
          PH_SYNC: begin
            pid_d   = rx_byte_i;
            cnt_d   = '0;
            phase_d = PH_ID;
          end
          PH_ID: begin
            store_we = (cnt_q < 4'(MAX_DATA));
            last_d   = rx_byte_i;
            if (cnt_q < 4'(MAX_DATA + 1)) begin
              cnt_d = cnt_q + 4'd1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_EMPTY;
      idle_q  <= '0;
      pid_q   <= '0;
      last_q  <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      idle_q  <= idle_d;
      pid_q   <= pid_d;
      last_q  <= last_d;
      cnt_q   <= cnt_d;
    end
  end

  // data bytes, written in arrival order
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_DATA; k++) begin
      if (store_we && (cnt_q == 4'(k))) begin
        store_q[k] <= rx_byte_i;
      end
    end
  end

  // closed frame contents
  assign frame_o.has_id    = (phase_q == PH_ID);
  assign frame_o.pid       = pid_q;
  assign frame_o.cnt       = cnt_q;
  assign frame_o.last_byte = last_q;

  for (genvar g = 0; g < LFR_DATA_SLOTS; g++) begin : g_slot
    if (g < MAX_DATA) begin : g_used
      assign frame_o.data[g] = store_q[g];
    end else begin : g_unused
      assign frame_o.data[g] = '0;
    end
  end

endmodule

// ===== hdl/lfr_frame_queue.sv =====
module lfr_frame_queue import lfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  lfr_frame_t frame_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output lfr_frame_t head_o
);

  // two closed frames may wait between front and back
  lfr_frame_t       slot_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       count_q;

  assign full_o  = count_q[1];
  assign empty_o = (count_q == 2'd0);
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= frame_i;
    end
  end

endmodule

// ===== hdl/lfr_back.sv =====
module lfr_back import lfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  lfr_frame_t  q_head_i,
  output logic        q_pop_o,
  input  logic [63:0] id_enable_mask_i,
  input  logic        pop_i,
  output logic        out_valid_o,
  output lfr_result_t out_o
);

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_SUM  = 2'd1,
    B_EMIT = 2'd2
  } back_state_e;

  back_state_e state_q, state_d;
  lfr_frame_t  frame_q, frame_d;
  lfr_status_e status_q, status_d;
  logic        match_q, match_d;
  logic [3:0]  n_q, n_d;
  logic [3:0]  idx_q, idx_d;
  logic [7:0]  enh_q, enh_d;
  logic [7:0]  cls_q, cls_d;
  logic        out_valid_q, out_valid_d;
  lfr_result_t out_q, out_d;

  logic       slot_free;
  logic       frame_ok;
  logic       has_data;
  logic       is_last;
  logic [7:0] cur_byte;

  assign slot_free = !out_valid_q || pop_i;
  assign cur_byte  = frame_q.data[idx_q[2:0]];
  assign frame_ok  = (status_q == ST_OK);
  assign has_data  = frame_ok && (n_q != 4'd0);
  assign is_last   = !has_data || ((idx_q + 4'd1) == n_q);

  // classify, sum one byte a cycle for frames that pass, then stream the results out
  always_comb begin
    state_d     = state_q;
    frame_d     = frame_q;
    status_d    = status_q;
    match_d     = match_q;
    n_d         = n_q;
    idx_d       = idx_q;
    enh_d       = enh_q;
    cls_d       = cls_q;
    out_valid_d = out_valid_q && !pop_i;
    out_d       = out_q;
    q_pop_o     = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          frame_d = q_head_i;
          idx_d   = '0;
          enh_d   = q_head_i.pid;
          cls_d   = '0;
          match_d = 1'b0;
          n_d     = q_head_i.cnt - 4'd1;
          priority if (!q_head_i.has_id) begin
            status_d = ST_NO_SYNC;
            state_d  = B_EMIT;
          end else if (lfr_parity(q_head_i.pid[5:0]) != q_head_i.pid) begin
            status_d = ST_PARITY;
            state_d  = B_EMIT;
          end else if (q_head_i.cnt == 4'd0) begin
            status_d = ST_NO_BYTES;
            state_d  = B_EMIT;
          end else begin
            status_d = ST_OK;
            state_d  = B_SUM;
          end
        end
      end
      B_SUM: begin
        if (idx_q == n_q) begin
          idx_d   = '0;
          state_d = B_EMIT;
          priority if ((frame_q.last_byte != ~enh_q) && (frame_q.last_byte != ~cls_q)) begin
            status_d = ST_CHECKSUM;
          end else if (!id_enable_mask_i[frame_q.pid[5:0]]) begin
            status_d = ST_NOT_ENABLED;
          end else begin
            status_d = ST_OK;
            match_d  = (frame_q.last_byte == ~enh_q);
          end
        end else begin
          enh_d = lfr_wrap_add(enh_q, cur_byte);
          cls_d = lfr_wrap_add(cls_q, cur_byte);
          idx_d = idx_q + 4'd1;
        end
      end
      B_EMIT: begin
        if (slot_free) begin
          out_valid_d            = 1'b1;
          out_d.status           = status_q;
          out_d.pid              = (status_q == ST_NO_SYNC) ? 8'd0 : frame_q.pid;
          out_d.data_count       = frame_ok ? n_q : 4'd0;
          out_d.byte_index       = has_data ? idx_q[2:0] : 3'd0;
          out_d.data_byte        = has_data ? cur_byte : 8'd0;
          out_d.matched_enhanced = frame_ok && match_q;
          out_d.last             = is_last;
          if (is_last) begin
            state_d = B_IDLE;
          end else begin
            idx_d = idx_q + 4'd1;
          end
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      status_q    <= ST_OK;
      match_q     <= 1'b0;
      n_q         <= '0;
      idx_q       <= '0;
      enh_q       <= '0;
      cls_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      match_q     <= match_d;
      n_q         <= n_d;
      idx_q       <= idx_d;
      enh_q       <= enh_d;
      cls_q       <= cls_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== hdl/lin_frame_receiver.sv =====
// channel   direction  handshake           payload
// input     in         push / full         action_i, rx_byte_i
// result    out        empty / pop         status_o .. last_o
// config    in         cfg_we_i            cfg_addr_i, cfg_wdata_i
//
// an input beat is taken in the cycle push is high; bytes and ticks never stall while the frame queue has room
// a closing tick pushes the frame into a two-entry queue; the back end then classifies it,
// sums its n data bytes one per cycle (frames that fail classification skip the sum), and
// streams max(1, n) results, one per cycle while pop keeps up
// full rises only while both queue entries hold frames; stalls on pop back up into the queue
// reset clears the frame state, the queue and the result valid flag; registers take their defaults
`include "lin_frame_receiver_defines.svh"

module lin_frame_receiver import lfr_pkg::*; #(
  parameter int unsigned MAX_DATA = LFR_MAX_DATA
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic        action_i,
  input  logic [7:0]  rx_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic [5:0]  frame_id_o,
  output logic [7:0]  protected_id_o,
  output logic [3:0]  data_count_o,
  output logic [2:0]  byte_index_o,
  output logic [7:0]  data_byte_o,
  output logic        matched_enhanced_o,
  output logic        last_o
);

  logic [15:0] gap_ticks_q;
  logic [7:0]  sync_value_q;
  logic [63:0] id_enable_mask_q;

  logic        in_accept;
  logic        front_push;
  lfr_frame_t  front_frame;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;
  lfr_frame_t  q_head;
  logic        out_valid;
  lfr_result_t result;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_ticks_q      <= LFR_GAP_RESET;
      sync_value_q     <= LFR_SYNC_RESET;
      id_enable_mask_q <= LFR_MASK_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_GAP_TICKS: gap_ticks_q      <= cfg_wdata_i[15:0];
        CFG_SYNC:      sync_value_q     <= cfg_wdata_i[7:0];
        CFG_ID_MASK:   id_enable_mask_q <= cfg_wdata_i;
        default:       gap_ticks_q      <= gap_ticks_q;
      endcase
    end
  end

  assign full      = q_full;
  assign in_accept = push && !q_full;

  lfr_front #(
    .MAX_DATA (MAX_DATA)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .action_i     (action_i),
    .rx_byte_i    (rx_byte_i),
    .gap_ticks_i  (gap_ticks_q),
    .sync_value_i (sync_value_q),
    .push_o       (front_push),
    .frame_o      (front_frame)
  );

  lfr_frame_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .frame_i (front_frame),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  lfr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_head_i         (q_head),
    .q_pop_o          (q_pop),
    .id_enable_mask_i (id_enable_mask_q),
    .pop_i            (pop),
    .out_valid_o      (out_valid),
    .out_o            (result)
  );

  // result ports
  assign empty              = !out_valid;
  assign status_o           = result.status;
  assign frame_id_o         = result.pid[5:0];
  assign protected_id_o     = result.pid;
  assign data_count_o       = result.data_count;
  assign byte_index_o       = result.byte_index;
  assign data_byte_o        = result.data_byte;
  assign matched_enhanced_o = result.matched_enhanced;
  assign last_o             = result.last;

  // an error frame is a single beat with no data
  `LFR_ASSERT(a_error_single, (!empty && (status_o != ST_OK)) |-> (last_o && (data_count_o == 4'd0) && (data_byte_o == 8'd0)), "error result is not a lone empty beat")
  // a data beat sits inside the frame's byte count
  `LFR_ASSERT(a_index_range, (!empty && (data_count_o != 4'd0)) |-> ({1'b0, byte_index_o} < data_count_o), "byte index beyond data count")
  // the queue never takes a frame while full
  `LFR_ASSERT(a_queue_overrun, q_full |-> !front_push, "frame pushed into a full queue")
  // after reset nothing waits on the result side
  `LFR_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> empty || rst_ni, "result pending right after reset")

endmodule
